/* rtl/core/pclc_pkg.sv */
package pclc_pkg;

  // Digits in one PIN
  localparam int CODE_LENGTH = 5;
  localparam int CNT_W = $clog2(CODE_LENGTH + 1);

  // Decoded key values
  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_CLEAR = 4'd10;
  localparam logic [3:0] KEY_NONE = 4'd11;

  // Failure counter limits
  localparam logic [3:0] FAIL_SAT = 4'd15;
  localparam logic [3:0] MAX_FAIL_RESET = 4'd3;

  typedef enum logic [3:0] {
    ST_TAKEN      = 4'd0,
    ST_CLEARED    = 4'd1,
    ST_UNLOCK     = 4'd2,
    ST_WRONG      = 4'd3,
    ST_LOCKOUT    = 4'd4,
    ST_CONFIRM    = 4'd5,
    ST_SAVED      = 4'd6,
    ST_MISMATCH   = 4'd7,
    ST_RESET_DONE = 4'd8
  } pclc_status_t;

  typedef logic [CODE_LENGTH-1:0][3:0] pclc_code_t;

  typedef struct packed {
    logic       req_type;
    logic [3:0] key_code;
  } pclc_in_t;

  typedef struct packed {
    pclc_status_t status;
    logic [2:0]   digits_entered;
    logic         in_setup;
    logic [3:0]   failures;
    logic [19:0]  saved_pin;
  } pclc_out_t;

  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic [CNT_W-1:0] confirm_count;
    logic             confirm_phase;
    logic             setup_mode;
    logic [3:0]       fail_count;
  } pclc_ctrl_t;

  // Map a keypad index (row + column*4) to its digit or clear key
  function automatic logic [3:0] key_value(input logic [3:0] code);
    logic [3:0] v;
    case (code)
      4'd0:    v = 4'd1;
      4'd1:    v = 4'd4;
      4'd2:    v = 4'd7;
      4'd3:    v = KEY_CLEAR;
      4'd4:    v = 4'd2;
      4'd5:    v = 4'd5;
      4'd6:    v = 4'd8;
      4'd7:    v = 4'd0;
      4'd8:    v = 4'd3;
      4'd9:    v = 4'd6;
      4'd10:   v = 4'd9;
      4'd11:   v = KEY_CLEAR;
      default: v = KEY_NONE;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/pclc_step.sv */
module pclc_step
  import pclc_pkg::*;
(
  input  pclc_in_t   item,
  input  pclc_ctrl_t ctrl,
  input  pclc_code_t entry,
  input  pclc_code_t confirm,
  input  pclc_code_t stored,
  input  logic [3:0] max_failures,
  output pclc_ctrl_t ctrl_nxt,
  output pclc_code_t entry_nxt,
  output pclc_code_t confirm_nxt,
  output logic       store_en,
  output pclc_out_t  result
);

  // Evaluate one key event against the current lock state
  always_comb begin
    logic [3:0]  key;
    logic [3:0]  fail_inc;
    logic [19:0] saved;
    pclc_status_t status;

    ctrl_nxt = ctrl;
    entry_nxt = entry;
    confirm_nxt = confirm;
    store_en = 1'b0;
    status = ST_TAKEN;
    saved = '0;
    fail_inc = (ctrl.fail_count < FAIL_SAT) ? ctrl.fail_count + 4'd1 : ctrl.fail_count;

    if (item.req_type) begin
      key = KEY_NONE;
      ctrl_nxt.setup_mode = 1'b1;
      ctrl_nxt.confirm_phase = 1'b0;
      ctrl_nxt.entry_count = '0;
      ctrl_nxt.confirm_count = '0;
      status = ST_RESET_DONE;
    end else begin
      key = key_value(item.key_code);
    end

    if (key == KEY_CLEAR) begin
      ctrl_nxt.entry_count = '0;
      if (ctrl.setup_mode) begin
        ctrl_nxt.confirm_count = '0;
        ctrl_nxt.confirm_phase = 1'b0;
      end
      status = ST_CLEARED;
    end else if (key <= DIGIT_MAX) begin
      if (ctrl.setup_mode && ctrl.confirm_phase) begin
        // Confirmation entry
        if (ctrl.confirm_count < CNT_W'(CODE_LENGTH)) begin
          for (int i = 0; i < CODE_LENGTH; i++) begin
            if (ctrl.confirm_count == CNT_W'(i)) confirm_nxt[i] = key;
          end
          ctrl_nxt.confirm_count = ctrl.confirm_count + CNT_W'(1);
          if (ctrl.confirm_count == CNT_W'(CODE_LENGTH - 1)) begin
            if (entry == confirm_nxt) begin
              store_en = 1'b1;
              for (int i = 0; i < CODE_LENGTH; i++) begin
                saved = {saved[15:0], confirm_nxt[i]};
              end
              ctrl_nxt.setup_mode = 1'b0;
              ctrl_nxt.confirm_phase = 1'b0;
              ctrl_nxt.entry_count = '0;
              status = ST_SAVED;
            end else begin
              status = ST_MISMATCH;
            end
            ctrl_nxt.confirm_count = '0;
          end
        end
      end else if (ctrl.entry_count < CNT_W'(CODE_LENGTH)) begin
        // First entry in setup, or an unlock attempt
        for (int i = 0; i < CODE_LENGTH; i++) begin
          if (ctrl.entry_count == CNT_W'(i)) entry_nxt[i] = key;
        end
        ctrl_nxt.entry_count = ctrl.entry_count + CNT_W'(1);
        if (ctrl.entry_count == CNT_W'(CODE_LENGTH - 1)) begin
          ctrl_nxt.entry_count = '0;
          if (ctrl.setup_mode) begin
            ctrl_nxt.confirm_phase = 1'b1;
            ctrl_nxt.confirm_count = '0;
            status = ST_CONFIRM;
          end else if (entry_nxt == stored) begin
            ctrl_nxt.fail_count = '0;
            status = ST_UNLOCK;
          end else if (fail_inc >= max_failures) begin
            ctrl_nxt.fail_count = '0;
            status = ST_LOCKOUT;
          end else begin
            ctrl_nxt.fail_count = fail_inc;
            status = ST_WRONG;
          end
        end
      end
    end

    result.status = status;
    result.digits_entered = (ctrl_nxt.setup_mode && ctrl_nxt.confirm_phase) ?
                            3'(ctrl_nxt.confirm_count) : 3'(ctrl_nxt.entry_count);
    result.in_setup = ctrl_nxt.setup_mode;
    result.failures = ctrl_nxt.fail_count;
    result.saved_pin = saved;
  end

endmodule

/* rtl/core/pin_code_lock_controller_unit.sv */
// PIN code lock controller.
// Input channel: in_valid / in_stall / in_data carry one key event per beat,
// either a keypad index (req_type 0) or a PIN reset request (req_type 1).
// Result channel: out_valid / out_stall / out_data return exactly one result
// beat per input beat, in order: status, digits in the active entry buffer,
// setup flag, failure count and, on a save, the new PIN.
// Configuration: cfg_wr_en / cfg_wr_data write the lockout limit; write it
// only while no beat is in flight.
// Path: an accepted beat passes through the input register, then the result
// register, which drives out_valid. Throughput: one beat per cycle while
// out_stall is low, set by the combinational state update between the two registers.
// Reset: the block enters setup mode with no PIN, all counts zero and the
// lockout limit at three.
// Stall: while out_stall holds a result, the result register keeps it and
// one more beat waits in the input register; in_stall rises only then.
module pin_code_lock_controller_unit
  import pclc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  pclc_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output pclc_out_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  logic       s1_valid_r;
  pclc_in_t   s1_data_r;
  logic       out_valid_r;
  pclc_out_t  out_data_r;
  logic [3:0] max_fail_r;

  pclc_ctrl_t ctrl_r;
  pclc_ctrl_t ctrl_nxt;
  pclc_code_t entry_r;
  pclc_code_t entry_nxt;
  pclc_code_t confirm_r;
  pclc_code_t confirm_nxt;
  pclc_code_t stored_r;
  logic       store_en;
  pclc_out_t  result;

  logic load_out;
  logic take_in;

  // Advance the held beat when the result register is free or draining
  assign load_out = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !load_out;
  assign take_in = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  pclc_step u_step (
    .item         (s1_data_r),
    .ctrl         (ctrl_r),
    .entry        (entry_r),
    .confirm      (confirm_r),
    .stored       (stored_r),
    .max_failures (max_fail_r),
    .ctrl_nxt     (ctrl_nxt),
    .entry_nxt    (entry_nxt),
    .confirm_nxt  (confirm_nxt),
    .store_en     (store_en),
    .result       (result)
  );

  // Hold handshake state, lock control state and the lockout limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      max_fail_r <= MAX_FAIL_RESET;
      ctrl_r <= '{entry_count: '0, confirm_count: '0, confirm_phase: 1'b0,
                  setup_mode: 1'b1, fail_count: 4'd0};
    end else begin
      if (take_in) begin
        s1_valid_r <= 1'b1;
      end else if (load_out) begin
        s1_valid_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        ctrl_r <= ctrl_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        max_fail_r <= cfg_wr_data;
      end
    end
  end

  // Capture payload and digit buffers
  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_data_r <= in_data;
    end
    if (load_out) begin
      out_data_r <= result;
      entry_r <= entry_nxt;
      confirm_r <= confirm_nxt;
      if (store_en) begin
        stored_r <= confirm_nxt;
      end
    end
  end

  a_stall_needs_held_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked beat");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("advanced beat did not reach the result register");

  a_saved_leaves_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_SAVED) |->
      (!out_data_r.in_setup && out_data_r.digits_entered == 3'd0))
    else $error("save result still reports setup mode");

  a_lockout_clears_failures: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_LOCKOUT) |-> out_data_r.failures == 4'd0)
    else $error("lockout left a failure count");

  a_counts_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_r.entry_count < CNT_W'(CODE_LENGTH)) &&
      (ctrl_r.confirm_count < CNT_W'(CODE_LENGTH)))
    else $error("digit count ran past the code length");

endmodule

/* verif/pin_code_lock_controller_unit_tb.sv */
`timescale 1ns / 100ps

module pin_code_lock_controller_unit_tb
  import pclc_pkg::*;
();

  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_BEATS = 290;
  localparam int QUIET_FIRST = 700;
  localparam int QUIET_LAST = 900;

  localparam logic REQ_KEY = 1'b0;
  localparam logic REQ_PIN_RESET = 1'b1;
  localparam logic [3:0] KEY_STAR = 4'd3;
  localparam logic [3:0] KEY_HASH = 4'd11;
  localparam logic [3:0] KEY_IDX_LAST = 4'd11;

  // keypad index 11..0 -> decoded digit or clear
  localparam logic [11:0][3:0] KEY_MAP = {
    KEY_CLEAR, 4'd9, 4'd6, 4'd3,
    4'd0, 4'd8, 4'd5, 4'd2,
    KEY_CLEAR, 4'd7, 4'd4, 4'd1
  };
  // digit 9..0 -> keypad index
  localparam logic [9:0][3:0] DIGIT_KEY = {
    4'd10, 4'd6, 4'd2, 4'd9, 4'd5, 4'd1, 4'd8, 4'd4, 4'd0, 4'd7
  };

  typedef logic [CODE_LENGTH-1:0][3:0] pin_digits_t;

  typedef struct {
    pclc_in_t  beat;
    bit        typed;
    pclc_out_t want;
  } key_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  pclc_in_t   in_data;
  logic       out_valid;
  logic       out_stall;
  pclc_out_t  out_data;
  logic       cfg_wr_en;
  logic [3:0] cfg_wr_data;

  // lock state as the block should hold it
  pin_digits_t lock_pin = '0;
  pin_digits_t entry_buf = '0;
  pin_digits_t confirm_buf = '0;
  int          entry_cnt = 0;
  int          confirm_cnt = 0;
  bit          confirm_ph = 1'b0;
  bit          setup_on = 1'b1;
  logic [3:0]  fail_cnt = '0;
  logic [3:0]  fail_limit = MAX_FAIL_RESET;

  pclc_out_t   expected_results[$];
  key_row_t    key_rows[32];
  int          row_count = 0;
  pin_digits_t plan_pin = '0;
  int          beats_sent = 0;
  int          results_seen = 0;
  int          err_count = 0;
  int          idle_cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  pin_code_lock_controller_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Advance the lock state by one beat and return the result it yields
  function automatic pclc_out_t lock_step(input pclc_in_t b);
    pclc_out_t   r;
    logic [3:0]  key;
    logic [19:0] packed_pin;
    r = '0;
    r.status = ST_TAKEN;
    key = KEY_NONE;
    packed_pin = '0;
    if (b.req_type == REQ_PIN_RESET) begin
      setup_on = 1'b1;
      confirm_ph = 1'b0;
      entry_cnt = 0;
      confirm_cnt = 0;
      r.status = ST_RESET_DONE;
    end else if (b.key_code <= KEY_IDX_LAST) begin
      key = KEY_MAP[b.key_code];
    end

    if (key == KEY_CLEAR) begin
      entry_cnt = 0;
      if (setup_on) begin
        confirm_cnt = 0;
        confirm_ph = 1'b0;
      end
      r.status = ST_CLEARED;
    end else if (key <= DIGIT_MAX) begin
      if (!setup_on) begin
        // unlock attempt
        if (entry_cnt < CODE_LENGTH) begin
          entry_buf[entry_cnt] = key;
          entry_cnt++;
          if (entry_cnt == CODE_LENGTH) begin
            if (entry_buf == lock_pin) begin
              fail_cnt = '0;
              r.status = ST_UNLOCK;
            end else begin
              if (fail_cnt < FAIL_SAT) fail_cnt++;
              if (fail_cnt >= fail_limit) begin
                fail_cnt = '0;
                r.status = ST_LOCKOUT;
              end else begin
                r.status = ST_WRONG;
              end
            end
            entry_cnt = 0;
          end
        end
      end else if (confirm_ph) begin
        // second entry of a new PIN
        if (confirm_cnt < CODE_LENGTH) begin
          confirm_buf[confirm_cnt] = key;
          confirm_cnt++;
          if (confirm_cnt == CODE_LENGTH) begin
            if (entry_buf == confirm_buf) begin
              lock_pin = confirm_buf;
              for (int i = 0; i < CODE_LENGTH; i++)
                packed_pin = {packed_pin[15:0], lock_pin[i]};
              setup_on = 1'b0;
              confirm_ph = 1'b0;
              entry_cnt = 0;
              r.status = ST_SAVED;
            end else begin
              r.status = ST_MISMATCH;
            end
            confirm_cnt = 0;
          end
        end
      end else begin
        // first entry of a new PIN
        if (entry_cnt < CODE_LENGTH) begin
          entry_buf[entry_cnt] = key;
          entry_cnt++;
          if (entry_cnt == CODE_LENGTH) begin
            confirm_ph = 1'b1;
            confirm_cnt = 0;
            entry_cnt = 0;
            r.status = ST_CONFIRM;
          end
        end
      end
    end

    r.digits_entered = 3'((setup_on && confirm_ph) ? confirm_cnt : entry_cnt);
    r.in_setup = setup_on;
    r.failures = fail_cnt;
    r.saved_pin = packed_pin;
    return r;
  endfunction

  // Offer one beat, hold it until accepted, then queue its result
  task automatic send_beat(input pclc_in_t b, input bit typed, input pclc_out_t want);
    pclc_out_t predicted;
    bit        gaps_on;
    gaps_on = !(beats_sent >= QUIET_FIRST && beats_sent < QUIET_LAST);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    predicted = lock_step(b);
    expected_results.push_back(typed ? want : predicted);
    if (b.req_type == REQ_PIN_RESET || b.key_code <= KEY_IDX_LAST) beats_sent++;
  endtask

  task automatic send_key(input logic req, input logic [3:0] code);
    pclc_in_t b;
    b.req_type = req;
    b.key_code = code;
    send_beat(b, 1'b0, '0);
  endtask

  task automatic add_row(input logic req, input logic [3:0] code, input bit typed,
                         input pclc_status_t st, input logic [2:0] digits,
                         input logic setup, input logic [3:0] fails);
    key_rows[row_count].beat.req_type = req;
    key_rows[row_count].beat.key_code = code;
    key_rows[row_count].typed = typed;
    key_rows[row_count].want.status = st;
    key_rows[row_count].want.digits_entered = digits;
    key_rows[row_count].want.in_setup = setup;
    key_rows[row_count].want.failures = fails;
    key_rows[row_count].want.saved_pin = '0;
    row_count++;
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fail_limit(input logic [3:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    fail_limit = v;
  endtask

  task automatic send_pin(input pin_digits_t p);
    for (int i = 0; i < CODE_LENGTH; i++) send_key(REQ_KEY, DIGIT_KEY[p[i]]);
  endtask

  // Mostly well-formed setup and unlock sequences, some clears and noise
  task automatic run_random(input int target);
    pin_digits_t new_pin;
    pin_digits_t echo_pin;
    int          pick;
    int          n;
    int          pos;
    while (beats_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_key(REQ_PIN_RESET, 4'($urandom_range(15)));
        for (int i = 0; i < CODE_LENGTH; i++) new_pin[i] = 4'($urandom_range(9));
        echo_pin = new_pin;
        if ($urandom_range(9) < 2) begin
          pos = $urandom_range(CODE_LENGTH - 1);
          echo_pin[pos] = 4'((new_pin[pos] + $urandom_range(1, 9)) % 10);
        end
        send_pin(new_pin);
        send_pin(echo_pin);
        if (echo_pin == new_pin) plan_pin = new_pin;
      end else if (pick < 70) begin
        new_pin = plan_pin;
        if ($urandom_range(9) < 4) begin
          for (int i = 0; i < CODE_LENGTH; i++) new_pin[i] = 4'($urandom_range(9));
        end
        send_pin(new_pin);
      end else if (pick < 82) begin
        n = $urandom_range(CODE_LENGTH - 1);
        for (int i = 0; i < n; i++) send_key(REQ_KEY, DIGIT_KEY[$urandom_range(9)]);
        send_key(REQ_KEY, $urandom_range(1) ? KEY_HASH : KEY_STAR);
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          send_key($urandom_range(7) == 0, 4'($urandom_range(15)));
      end
    end
  endtask

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    pclc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        err_count++;
        $display("%0t: result with none expected, expected nothing actual %h",
                 $time, out_data);
      end else begin
        want = expected_results.pop_front();
        report_field("status", want.status, out_data.status);
        report_field("digits_entered", want.digits_entered, out_data.digits_entered);
        report_field("in_setup", want.in_setup, out_data.in_setup);
        report_field("failures", want.failures, out_data.failures);
        report_field("saved_pin", want.saved_pin, out_data.saved_pin);
      end
    end
  end

  // Receiver: random stalls, one long hold-off, one stretch with none
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 400) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 9);
      end
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [3:0] limits[5];
    int         target;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    limits[0] = 4'd15;
    limits[1] = 4'd0;
    limits[2] = 4'd1;
    limits[3] = 4'($urandom_range(2, 14));
    limits[4] = MAX_FAIL_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // clear and off-keypad codes straight after reset
    add_row(REQ_KEY, KEY_STAR, 1'b1, ST_CLEARED, 3'd0, 1'b1, 4'd0);
    add_row(REQ_KEY, 4'd15, 1'b1, ST_TAKEN, 3'd0, 1'b1, 4'd0);
    add_row(REQ_KEY, 4'd12, 1'b1, ST_TAKEN, 3'd0, 1'b1, 4'd0);
    // set up 9 0 9 0 9, then confirm it
    for (int k = 0; k < 2 * CODE_LENGTH; k++)
      add_row(REQ_KEY, DIGIT_KEY[((k % CODE_LENGTH) % 2) ? 0 : 9], 1'b0, ST_TAKEN,
              3'd0, 1'b0, 4'd0);
    // clear in unlock mode, then a wrong code of all zeros
    add_row(REQ_KEY, KEY_HASH, 1'b1, ST_CLEARED, 3'd0, 1'b0, 4'd0);
    for (int k = 0; k < CODE_LENGTH; k++)
      add_row(REQ_KEY, DIGIT_KEY[0], 1'b0, ST_TAKEN, 3'd0, 1'b0, 4'd0);
    // PIN reset keeps the failure count
    add_row(REQ_PIN_RESET, 4'd15, 1'b1, ST_RESET_DONE, 3'd0, 1'b1, 4'd1);
    add_row(REQ_PIN_RESET, 4'd0, 1'b1, ST_RESET_DONE, 3'd0, 1'b1, 4'd1);

    for (int r = 0; r < row_count; r++)
      send_beat(key_rows[r].beat, key_rows[r].typed, key_rows[r].want);
    plan_pin = 20'h90909;

    // one random phase per lockout limit
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_fail_limit(limits[ph]);
      target = beats_sent + PHASE_BEATS;
      run_random(target);
    end

    drain();
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
